FILE: rtl/pcx_pkg.sv
// shared types and constants for the pcx run-length scanline decoder
// no dependencies; used by the top level and the palette ram

package pcx_pkg;

  // marker at and above which a stream byte is a run count
  localparam logic [7:0] RUN_MARK = 8'hC0;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned RGB_W      = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_MODE   = 2'd0,
    CFG_LINE_BYTES   = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_MONO   = 2'd0,
    MODE_PLANE4 = 2'd1,
    MODE_PAL8   = 2'd2,
    MODE_RGB3   = 2'd3
  } plane_mode_e;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_PAL_WR = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_t;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] byte_pos;
    logic [1:0]  plane;
    logic [7:0]  byte_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        padding;
    logic        run_end;
    logic        frame_done;
  } out_t;

endpackage

FILE: rtl/pcx_pal_ram.sv
// palette memory: one write port, one registered read port
// depends on pcx_pkg for the entry width

module pcx_pal_ram #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(ENTRIES)-1:0]          waddr_i,
  input  logic [pcx_pkg::RGB_W-1:0]           wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(ENTRIES)-1:0]          raddr_i,
  output logic [pcx_pkg::RGB_W-1:0]           rdata_o
);

  logic [pcx_pkg::RGB_W-1:0] mem [ENTRIES];
  logic [pcx_pkg::RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pcx_rle_scanline_decoder.sv
// pcx run-length scanline decoder, top level
// a literal or run value beat registers its value and palette read, then loads its first byte
// throughput: one decoded byte per cycle unless the output stalls, paced by the emit counter;
//   n-byte beats hold input until their last byte loads; count, palette and empty-run beats do not
// reset: counters and run state clear, registers take their defaults, palette undefined
// depends on pcx_pkg and pcx_pal_ram

module pcx_rle_scanline_decoder #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [pcx_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pcx_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // compressed stream and palette writes
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  pcx_pkg::in_t                         in_data_i,
  // decoded bytes
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pcx_pkg::out_t                        out_data_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]  NUM_ENTRIES = 9'(PALETTE_ENTRIES);

  // configuration registers
  logic [1:0]  plane_mode_q;
  logic [15:0] line_bytes_q;
  logic [16:0] image_width_q;
  logic [16:0] image_height_q;

  // decode state
  logic [5:0]  pend_q, pend_d;
  logic        await_q, await_d;
  logic [5:0]  cnt_q, cnt_d;        // bytes still to emit for the current beat
  logic [7:0]  val_q;               // byte being emitted
  logic        rgb_ok_q;            // value lies inside the palette
  logic [15:0] line_pos_q, line_pos_d;
  logic [1:0]  plane_q, plane_d;
  logic [16:0] line_cnt_q, line_cnt_d;

  // output register
  logic          out_valid_q;
  pcx_pkg::out_t out_q, out_d;

  logic        in_fire;
  logic        load;                // move one byte into the output register
  logic        is_data;
  logic [5:0]  new_cnt;
  logic        pal_we;
  logic        pal_re;
  logic [pcx_pkg::RGB_W-1:0] pal_rdata;

  // emit side combinational terms
  logic [2:0]  planes;
  logic        line_end;
  logic        plane_end;
  logic        row_end;
  logic        mode_pal;
  logic [16:0] row_full;

  // a byte is pending and the output register is free or being drained this cycle
  assign load = (cnt_q != 6'd0) && (!out_valid_q || out_ready_i);

  // take a new beat when idle, or as the last byte of the current one leaves
  assign in_ready_o = (cnt_q == 6'd0) || ((cnt_q == 6'd1) && load);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_data    = (in_data_i.kind == pcx_pkg::KIND_DATA);

  // palette write ignores indexes past the table
  assign pal_we = in_fire && !is_data && ({1'b0, in_data_i.pal_index} < NUM_ENTRIES);

  // run decoding of an accepted data beat
  always_comb begin
    pend_d  = pend_q;
    await_d = await_q;
    new_cnt = 6'd0;
    if (in_fire && is_data) begin
      if (await_q) begin
        // value byte of a run, an empty run emits nothing
        new_cnt = pend_q;
        pend_d  = 6'd0;
        await_d = 1'b0;
      end else if (in_data_i.data_byte < pcx_pkg::RUN_MARK) begin
        new_cnt = 6'd1;
      end else begin
        pend_d  = in_data_i.data_byte[5:0];
        await_d = 1'b1;
      end
    end
  end

  assign pal_re = in_fire && is_data && (new_cnt != 6'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = cnt_q - 6'd1;
    end
    if (new_cnt != 6'd0) begin
      cnt_d = new_cnt;
    end
  end

  // planes per row for the current mode
  always_comb begin
    unique case (plane_mode_q)
      pcx_pkg::MODE_PLANE4: planes = 3'd4;
      pcx_pkg::MODE_RGB3:   planes = 3'd3;
      default:              planes = 3'd1;
    endcase
  end

  assign mode_pal  = (plane_mode_q == pcx_pkg::MODE_PAL8);
  assign line_end  = ({1'b0, line_pos_q} + 17'd1) >= {1'b0, line_bytes_q};
  assign plane_end = ({1'b0, plane_q} + 3'd1) >= planes;
  assign row_end   = ({1'b0, line_cnt_q} + 18'd1) >= {1'b0, image_height_q};
  assign row_full  = image_height_q - 17'd1 - line_cnt_q;

  // position counters step once per emitted byte
  always_comb begin
    line_pos_d = line_pos_q;
    plane_d    = plane_q;
    line_cnt_d = line_cnt_q;
    if (load) begin
      if (line_end) begin
        line_pos_d = 16'd0;
        if (plane_end) begin
          plane_d = 2'd0;
          if (row_end) begin
            line_cnt_d = 17'd0;
          end else begin
            line_cnt_d = line_cnt_q + 17'd1;
          end
        end else begin
          plane_d = plane_q + 2'd1;
        end
      end else begin
        line_pos_d = line_pos_q + 16'd1;
      end
    end
  end

  // result fields for the byte being loaded
  always_comb begin
    out_d            = out_q;
    out_d.row        = row_full[15:0];
    out_d.byte_pos   = line_pos_q;
    out_d.plane      = plane_q;
    out_d.byte_value = val_q;
    if (mode_pal && rgb_ok_q) begin
      out_d.red   = pal_rdata[23:16];
      out_d.green = pal_rdata[15:8];
      out_d.blue  = pal_rdata[7:0];
    end else begin
      out_d.red   = 8'd0;
      out_d.green = 8'd0;
      out_d.blue  = 8'd0;
    end
    out_d.padding    = mode_pal && ({1'b0, line_pos_q} >= image_width_q);
    out_d.run_end    = (cnt_q == 6'd1);
    out_d.frame_done = line_end && plane_end && row_end;
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_mode_q   <= pcx_pkg::MODE_PAL8;
      line_bytes_q   <= 16'd320;
      image_width_q  <= 17'd320;
      image_height_q <= 17'd200;
      pend_q         <= 6'd0;
      await_q        <= 1'b0;
      cnt_q          <= 6'd0;
      line_pos_q     <= 16'd0;
      plane_q        <= 2'd0;
      line_cnt_q     <= 17'd0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pcx_pkg::CFG_PLANE_MODE:   plane_mode_q   <= cfg_data_i[1:0];
          pcx_pkg::CFG_LINE_BYTES:   line_bytes_q   <= cfg_data_i[15:0];
          pcx_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          pcx_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      pend_q     <= pend_d;
      await_q    <= await_d;
      cnt_q      <= cnt_d;
      line_pos_q <= line_pos_d;
      plane_q    <= plane_d;
      line_cnt_q <= line_cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      val_q    <= in_data_i.data_byte;
      rgb_ok_q <= ({1'b0, in_data_i.data_byte} < NUM_ENTRIES);
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  pcx_pal_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (in_data_i.pal_index[IDX_W-1:0]),
    .wdata_i ({in_data_i.pal_red, in_data_i.pal_green, in_data_i.pal_blue}),
    .re_i    (pal_re && ({1'b0, in_data_i.data_byte} < NUM_ENTRIES)),
    .raddr_i (in_data_i.data_byte[IDX_W-1:0]),
    .rdata_o (pal_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
